[design/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg: shared types for the integer ALU
// Opcodes, error codes and the control word carried down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

  // Opcodes; codes above OP_COMMA are unsupported
  typedef enum logic [4:0] {
    OP_PLUS  = 5'd0,  OP_NEG  = 5'd1,  OP_LNOT = 5'd2,  OP_BNOT = 5'd3,
    OP_MUL   = 5'd4,  OP_DIV  = 5'd5,  OP_REM  = 5'd6,  OP_ADD  = 5'd7,
    OP_SUB   = 5'd8,  OP_SHL  = 5'd9,  OP_SHR  = 5'd10, OP_LT   = 5'd11,
    OP_LE    = 5'd12, OP_GT   = 5'd13, OP_GE   = 5'd14, OP_EQ   = 5'd15,
    OP_NE    = 5'd16, OP_AND  = 5'd17, OP_XOR  = 5'd18, OP_OR   = 5'd19,
    OP_LAND  = 5'd20, OP_LOR  = 5'd21, OP_COMMA = 5'd22
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_DIV0   = 2'd1,
    ERR_SHIFT  = 2'd2,
    ERR_OPCODE = 2'd3
  } err_t;

  // Which unit supplies the final value
  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2,
    K_REM    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    err_t  err;
    logic  q_neg;
    logic  r_neg;
  } ctrl_t;

endpackage

`default_nettype wire

[design/cia_in_if.sv]
// ----------------------------------------------------------------------------
// cia_in_if: operation channel
// Valid/ready channel carrying one opcode and two signed operands per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cia_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        action;
  logic signed [31:0] left_operand;
  logic signed [31:0] right_operand;

  modport source (output valid, action, left_operand, right_operand, input ready);
  modport sink   (input valid, action, left_operand, right_operand, output ready);
endinterface

`default_nettype wire

[design/cia_out_if.sv]
// ----------------------------------------------------------------------------
// cia_out_if: result channel
// Valid/ready channel carrying one signed result and an error code per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cia_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         error_code;

  modport source (output valid, result_value, error_code, input ready);
  modport sink   (input valid, result_value, error_code, output ready);
endinterface

`default_nettype wire

[design/c_operator_integer_alu_top.sv]
// ----------------------------------------------------------------------------
// c_operator_integer_alu_top: pipelined C-operator integer ALU
// One operation per word on DATA_WIDTH-bit two's complement operands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries an opcode and two signed 32-bit operands; out_ch returns
//   one signed 32-bit result and an error code for every word, in order.
//   Operands are taken at DATA_WIDTH bits and the result is sign-extended
//   or truncated to 32 bits.
//   A word passes from acceptance to a valid result through the input
//   register, decode, multiply sum, one stage per quotient bit of the
//   restoring divider, and the output register. All operations travel the
//   same path, so results leave in order.
//   Throughput is one word per cycle while the receiver takes every result.
//   The whole pipeline advances together: when the receiver holds off a
//   waiting result, every stage holds and in_ch.ready drops; nothing is
//   lost or repeated. Reset clears all valid bits; data is not cleared.
//   Errors (zero divisor, shift count outside 0..DATA_WIDTH-1, unsupported
//   opcode) return a result of zero.
// ----------------------------------------------------------------------------
`default_nettype none

module c_operator_integer_alu_top
  import cia_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cia_in_if.sink    in_ch,
  cia_out_if.source out_ch
);

  localparam int W  = DATA_WIDTH;
  localparam int SW = $clog2(W);
  localparam int HL = (W + 1) / 2;
  localparam int HH = W - HL;

  logic en;

  // Input register
  logic                s0_vld_r;
  logic [4:0]          s0_op_r;
  logic signed [W-1:0] s0_a_r;
  logic signed [W-1:0] s0_b_r;

  // Decode stage
  logic          s1_vld_r;
  ctrl_t         s1_ctrl_r;
  logic [W-1:0]  s1_res_r;
  logic [W-1:0]  s1_p0_r;
  logic [HH-1:0] s1_p1_r;
  logic [HH-1:0] s1_p2_r;
  logic [W-1:0]  s1_ma_r;
  logic [W-1:0]  s1_mb_r;

  // Divider chain
  logic         d_vld  [W+1];
  ctrl_t        d_ctrl [W+1];
  logic [W-1:0] d_res  [W+1];
  logic [W-1:0] d_rem  [W+1];
  logic [W-1:0] d_quo  [W+1];
  logic [W-1:0] d_dvs  [W+1];

  // Output register
  logic               out_vld_r;
  logic signed [31:0] out_res_r;
  err_t               out_err_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Take the operands at W bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op_r <= in_ch.action;
      s0_a_r  <= W'(in_ch.left_operand);
      s0_b_r  <= W'(in_ch.right_operand);
    end
  end

  // Decode: simple results, error code, partial products, magnitudes
  ctrl_t         ctrl_nxt;
  logic [W-1:0]  res_nxt;
  logic [W-1:0]  p0_nxt;
  logic [HH-1:0] p1_nxt;
  logic [HH-1:0] p2_nxt;
  logic          a_neg;
  logic          b_neg;
  logic          b_zero;
  logic          sh_bad;
  logic [SW-1:0] sh;
  logic [W-1:0]  one_w;

  always_comb begin
    a_neg    = s0_a_r[W-1];
    b_neg    = s0_b_r[W-1];
    b_zero   = (s0_b_r == '0);
    sh_bad   = b_neg || (s0_b_r >= W'(W));
    sh       = s0_b_r[SW-1:0];
    one_w    = W'(1);
    p0_nxt   = W'((2*HL)'(s0_a_r[HL-1:0]) * (2*HL)'(s0_b_r[HL-1:0]));
    p1_nxt   = s0_a_r[HH-1:0] * s0_b_r[W-1:HL];
    p2_nxt   = s0_a_r[W-1:HL] * s0_b_r[HH-1:0];
    ctrl_nxt.kind  = K_SIMPLE;
    ctrl_nxt.err   = ERR_NONE;
    ctrl_nxt.q_neg = a_neg ^ b_neg;
    ctrl_nxt.r_neg = a_neg;
    res_nxt  = '0;
    unique case (s0_op_r)
      OP_PLUS:  res_nxt = s0_a_r;
      OP_NEG:   res_nxt = -s0_a_r;
      OP_LNOT:  res_nxt = (s0_a_r == '0) ? one_w : '0;
      OP_BNOT:  res_nxt = ~s0_a_r;
      OP_MUL:   ctrl_nxt.kind = K_MUL;
      OP_DIV: begin
        ctrl_nxt.kind = K_DIV;
        if (b_zero) ctrl_nxt.err = ERR_DIV0;
      end
      OP_REM: begin
        ctrl_nxt.kind = K_REM;
        if (b_zero) ctrl_nxt.err = ERR_DIV0;
      end
      OP_ADD:   res_nxt = s0_a_r + s0_b_r;
      OP_SUB:   res_nxt = s0_a_r - s0_b_r;
      OP_SHL: begin
        res_nxt = s0_a_r << sh;
        if (sh_bad) ctrl_nxt.err = ERR_SHIFT;
      end
      OP_SHR: begin
        res_nxt = s0_a_r >>> sh;
        if (sh_bad) ctrl_nxt.err = ERR_SHIFT;
      end
      OP_LT:    res_nxt = (s0_a_r <  s0_b_r) ? one_w : '0;
      OP_LE:    res_nxt = (s0_a_r <= s0_b_r) ? one_w : '0;
      OP_GT:    res_nxt = (s0_a_r >  s0_b_r) ? one_w : '0;
      OP_GE:    res_nxt = (s0_a_r >= s0_b_r) ? one_w : '0;
      OP_EQ:    res_nxt = (s0_a_r == s0_b_r) ? one_w : '0;
      OP_NE:    res_nxt = (s0_a_r != s0_b_r) ? one_w : '0;
      OP_AND:   res_nxt = s0_a_r & s0_b_r;
      OP_XOR:   res_nxt = s0_a_r ^ s0_b_r;
      OP_OR:    res_nxt = s0_a_r | s0_b_r;
      OP_LAND:  res_nxt = (!b_zero && s0_a_r != '0) ? one_w : '0;
      OP_LOR:   res_nxt = (!b_zero || s0_a_r != '0) ? one_w : '0;
      OP_COMMA: res_nxt = s0_b_r;
      default:  ctrl_nxt.err = ERR_OPCODE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ctrl_r <= ctrl_nxt;
      s1_res_r  <= res_nxt;
      s1_p0_r   <= p0_nxt;
      s1_p1_r   <= p1_nxt;
      s1_p2_r   <= p2_nxt;
      s1_ma_r   <= a_neg ? -s0_a_r : s0_a_r;
      s1_mb_r   <= b_neg ? -s0_b_r : s0_b_r;
    end
  end

  // Sum the partial products and load the divider
  logic         s2_vld_r;
  ctrl_t        s2_ctrl_r;
  logic [W-1:0] s2_res_r;
  logic [W-1:0] s2_quo_r;
  logic [W-1:0] s2_dvs_r;
  logic [W-1:0] mul_sum;

  always_comb begin
    mul_sum = s1_p0_r + {HH'(s1_p1_r + s1_p2_r), {HL{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctrl_r <= s1_ctrl_r;
      s2_res_r  <= (s1_ctrl_r.kind == K_MUL) ? mul_sum : s1_res_r;
      s2_quo_r  <= s1_ma_r;
      s2_dvs_r  <= s1_mb_r;
    end
  end

  assign d_vld[0]  = s2_vld_r;
  assign d_ctrl[0] = s2_ctrl_r;
  assign d_res[0]  = s2_res_r;
  assign d_rem[0]  = '0;
  assign d_quo[0]  = s2_quo_r;
  assign d_dvs[0]  = s2_dvs_r;

  // One quotient bit per stage
  for (genvar i = 0; i < W; i++) begin : g_div
    cia_div_stage #(.W(W)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (d_vld[i]),
      .ctrl_i (d_ctrl[i]),
      .res_i  (d_res[i]),
      .rem_i  (d_rem[i]),
      .quo_i  (d_quo[i]),
      .dvs_i  (d_dvs[i]),
      .vld_o  (d_vld[i+1]),
      .ctrl_o (d_ctrl[i+1]),
      .res_o  (d_res[i+1]),
      .rem_o  (d_rem[i+1]),
      .quo_o  (d_quo[i+1]),
      .dvs_o  (d_dvs[i+1])
    );
  end

  // Select the unit, apply signs, force zero on error
  ctrl_t               fin_ctrl;
  logic signed [W-1:0] fin_res;

  always_comb begin
    fin_ctrl = d_ctrl[W];
    unique case (fin_ctrl.kind)
      K_DIV:    fin_res = fin_ctrl.q_neg ? -d_quo[W] : d_quo[W];
      K_REM:    fin_res = fin_ctrl.r_neg ? -d_rem[W] : d_rem[W];
      K_MUL:    fin_res = d_res[W];
      K_SIMPLE: fin_res = d_res[W];
      default:  fin_res = d_res[W];
    endcase
    if (fin_ctrl.err != ERR_NONE) fin_res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= d_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= 32'(fin_res);
      out_err_r <= fin_ctrl.err;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.error_code   = out_err_r;

`ifndef ASSERT_OFF
  // Every error word leaves with a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_err_r != ERR_NONE |-> out_res_r == 32'sd0)
    else $error("error word with non-zero value");

  // A division without error never enters the divider with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && (s2_ctrl_r.kind == K_DIV || s2_ctrl_r.kind == K_REM)
      && s2_ctrl_r.err == ERR_NONE |-> s2_dvs_r != '0)
    else $error("zero divisor reached the divider unflagged");

  // A stall freezes the valid bits of the front stages
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s0_vld_r) && $stable(s1_vld_r) && $stable(s2_vld_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

[design/cia_div_stage.sv]
// ----------------------------------------------------------------------------
// cia_div_stage: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and registers the step together with the word's side data.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_div_stage
  import cia_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         vld_i,
  input  wire ctrl_t        ctrl_i,
  input  wire logic [W-1:0] res_i,
  input  wire logic [W-1:0] rem_i,
  input  wire logic [W-1:0] quo_i,
  input  wire logic [W-1:0] dvs_i,
  output logic              vld_o,
  output ctrl_t             ctrl_o,
  output logic [W-1:0]      res_o,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      dvs_o
);

  logic [W-1:0] trial;
  logic         fits;
  logic [W-1:0] rem_nxt;
  logic [W-1:0] quo_nxt;

  // Trial subtract; the partial remainder stays below the divisor
  always_comb begin
    trial   = {rem_i[W-2:0], quo_i[W-1]};
    fits    = (trial >= dvs_i);
    rem_nxt = fits ? (trial - dvs_i) : trial;
    quo_nxt = {quo_i[W-2:0], fits};
  end

  // Hold on stall, advance otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_o <= ctrl_i;
      res_o  <= res_i;
      rem_o  <= rem_nxt;
      quo_o  <= quo_nxt;
      dvs_o  <= dvs_i;
    end
  end

endmodule

`default_nettype wire
